@@ src/keypad_debounce_event_engine_defines.svh @@
// Assertion macros shared by the keypad engine.
`ifndef KEYPAD_DEBOUNCE_EVENT_ENGINE_DEFINES_SVH
`define KEYPAD_DEBOUNCE_EVENT_ENGINE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define KDE_ASSERT_IMP(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("%m: check failed");
// Next-cycle implication checked outside reset.
`define KDE_ASSERT_NXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("%m: check failed");
`endif

@@ src/kde_pkg.sv @@
`timescale 1ns / 1ps
package kde_pkg;
    typedef enum logic [3:0] {
        EV_START = 4'd0, EV_WAIT_RELEASE = 4'd1, EV_WAIT_READ = 4'd2, EV_LONG = 4'd3,
        EV_ON_RELEASE = 4'd4, EV_REP_DELAY = 4'd5, EV_REP_READY = 4'd6,
        EV_REP_GAP = 4'd7, EV_END = 4'd8
    } ev_stage_t;

    typedef enum logic [1:0] {
        DB_IDLE = 2'd0, DB_CONFIRM_PRESS = 2'd1, DB_HELD = 2'd2, DB_CONFIRM_REL = 2'd3
    } db_stage_t;

    typedef enum logic [1:0] {
        SEQ_IDLE = 2'd0, SEQ_ACK = 2'd1, SEQ_KEY = 2'd2, SEQ_OUT = 2'd3
    } seq_state_t;

    localparam logic [2:0] CFG_ON_PRESS    = 3'd0;
    localparam logic [2:0] CFG_ON_RELEASE  = 3'd1;
    localparam logic [2:0] CFG_LONG_PRESS  = 3'd2;
    localparam logic [2:0] CFG_REPEAT      = 3'd3;
    localparam logic [2:0] CFG_GROUP_MAP   = 3'd4;
    localparam logic [2:0] CFG_REP_DELAY   = 3'd5;
    localparam logic [2:0] CFG_REP_INTERVAL = 3'd6;
    localparam logic [2:0] CFG_LONG_TICKS  = 3'd7;

    // State of one key, as read from and written back to the key file.
    typedef struct packed {
        db_stage_t db;
        logic [2:0] db_cnt;
        logic pressed;
        ev_stage_t ev;
        logic [15:0] hold;
        logic ready;
        logic owner;
        logic proc;
        logic after;
    } key_state_t;

    // Settings for one key, as seen by the shared unit.
    typedef struct packed {
        logic on_press;
        logic on_release;
        logic long_press;
        logic repeat_en;
        logic [2:0] group;
        logic [15:0] rep_delay;
        logic [15:0] rep_interval;
        logic [15:0] long_ticks;
    } key_cfg_t;
endpackage

@@ src/kde_key_unit.sv @@
`timescale 1ns / 1ps
// Shared per-key unit: one debounce step and the event stages of one key.
module kde_key_unit
    import kde_pkg::*;
#(
    parameter int DEBOUNCE_TICKS = 4
) (
    input  key_state_t st_in,
    input  key_cfg_t   cfg,
    input  logic       pin_pressed,
    input  logic       lock_in,
    output key_state_t st_out,
    output logic       lock_out
);
    localparam logic [2:0] DbLimit = 3'(DEBOUNCE_TICKS);

    always_comb begin
        key_state_t s;
        logic lk;
        logic rel;
        logic [2:0] cnt_inc;
        logic [15:0] h;
        s = st_in;
        lk = lock_in;
        cnt_inc = s.db_cnt + 3'd1;
        case (s.db)
            DB_IDLE: begin
                if (pin_pressed) s.db = DB_CONFIRM_PRESS;
            end
            DB_CONFIRM_PRESS: begin
                s.db_cnt = cnt_inc;
                if (cnt_inc == DbLimit) begin
                    s.db_cnt = 3'd0;
                    if (!pin_pressed) s.db = DB_IDLE;
                    else begin
                        s.pressed = 1'b1;
                        s.db = DB_HELD;
                    end
                end
            end
            DB_HELD: begin
                if (!pin_pressed) s.db = DB_CONFIRM_REL;
            end
            default: begin
                s.db_cnt = cnt_inc;
                if (cnt_inc == DbLimit) begin
                    s.db_cnt = 3'd0;
                    if (pin_pressed) s.db = DB_HELD;
                    else begin
                        s.pressed = 1'b0;
                        s.db = DB_IDLE;
                    end
                end
            end
        endcase

        if (s.ev == EV_START) begin
            if (!(cfg.group != 3'd0 && lk && !s.owner) && s.pressed) begin
                if (cfg.on_press) begin
                    s.ready = 1'b1;
                    s.ev = cfg.repeat_en ? EV_REP_DELAY : EV_WAIT_RELEASE;
                end else if (cfg.on_release) begin
                    s.ev = EV_ON_RELEASE;
                end else if (cfg.long_press) begin
                    s.ev = EV_LONG;
                end
                s.proc = 1'b1;
                if (cfg.group != 3'd0) begin
                    lk = 1'b1;
                    s.owner = 1'b1;
                end
            end
        end
        rel = !s.pressed;
        if ((s.ev == EV_REP_DELAY || s.ev == EV_REP_READY || s.ev == EV_REP_GAP) && rel) begin
            s.hold = 16'd0;
            s.ev = EV_WAIT_READ;
        end
        h = (s.hold != 16'hFFFF) ? s.hold + 16'd1 : s.hold;
        if (s.ev == EV_REP_DELAY) begin
            s.hold = h;
            if (h >= cfg.rep_delay) begin
                s.hold = 16'd0;
                s.ev = EV_REP_READY;
            end
        end
        if (s.ev == EV_REP_READY && !s.ready) begin
            s.ready = 1'b1;
            s.ev = EV_REP_GAP;
        end
        h = (s.hold != 16'hFFFF) ? s.hold + 16'd1 : s.hold;
        if (s.ev == EV_REP_GAP) begin
            s.hold = h;
            if (h >= cfg.rep_interval) begin
                s.hold = 16'd0;
                s.ev = EV_REP_READY;
            end
        end
        if (s.ev == EV_ON_RELEASE && rel) begin
            s.ready = 1'b1;
            s.ev = EV_WAIT_READ;
        end
        if (s.ev == EV_LONG) begin
            s.hold = h;
            if (rel && h <= cfg.long_ticks) begin
                s.hold = 16'd0;
                s.ready = 1'b1;
                s.after = 1'b0;
                s.ev = EV_WAIT_READ;
            end else if (h > cfg.long_ticks) begin
                s.hold = 16'd0;
                s.ready = 1'b1;
                s.after = 1'b1;
                s.ev = cfg.repeat_en ? EV_REP_GAP : EV_WAIT_RELEASE;
            end
        end
        if (s.ev == EV_WAIT_RELEASE && rel) s.ev = EV_WAIT_READ;
        if (s.ev == EV_WAIT_READ && !s.ready) s.ev = EV_END;
        if (s.ev == EV_END) begin
            if (cfg.group != 3'd0) begin
                lk = 1'b0;
                s.owner = 1'b0;
            end
            s.ev = EV_START;
            s.proc = 1'b0;
        end
        st_out = s;
        lock_out = lk;
    end
endmodule

@@ src/keypad_debounce_event_engine.sv @@
`timescale 1ns / 1ps
// Keypad debounce and event engine.
// Input channel (s_axis_*): one word per scan tick, tdata = {read_ack_mask, pin_levels}.
// Pin level 0 means pressed. Acks clear the ready flags of the keys named.
// Result channel (m_axis_*): one word per tick, tdata from bit 0 up:
// ready_mask, pressed_mask, processing_mask, after_threshold_mask,
// all_released, all_finished, then zero fill to 40 bits.
// Configuration: cfg_we/cfg_index/cfg_wdata, to be written only while idle;
// the block itself does not enforce this. Each tick passes an ack step, one
// step per key through the single shared key unit, and a step to assemble the
// word. A new tick is taken only once the last one's word is assembled.
// Ready (s_axis_tready) is low while a tick is in work. A waiting result
// word does not block the input; a stalled receiver holds the next tick in
// its assembly step until the waiting word is taken.
// Reset clears all key state and loads the timing registers with 100, 20
// and 200 ticks; no clearing pass is needed.
module keypad_debounce_event_engine
    import kde_pkg::*;
#(
    parameter int NUM_KEYS = 8,
    parameter int DEBOUNCE_TICKS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // pin_levels[7:0], read_ack_mask[15:8]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // ready, pressed, processing, after, all_rel, all_fin
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_wdata
);
    `include "keypad_debounce_event_engine_defines.svh"
    localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam logic [KW-1:0] LastKey = KW'(NUM_KEYS - 1);

    logic [7:0] on_press_reg, on_release_reg, long_press_reg, repeat_reg;
    logic [23:0] group_map_reg;
    logic [15:0] rep_delay_reg, rep_interval_reg, long_ticks_reg;

    key_state_t keys_reg [NUM_KEYS];
    logic [7:0] lock_reg;
    logic [15:0] in_reg;
    logic [KW-1:0] key_reg;
    seq_state_t state_reg, state_next;
    logic [39:0] out_reg;
    logic out_valid_reg;
    logic out_free;

    key_state_t cur, upd;
    key_cfg_t kcfg;
    logic pin_pr, lock_in, lock_out;
    logic [2:0] grp;
    logic [7:0] key8;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            on_press_reg <= '0; on_release_reg <= '0; long_press_reg <= '0;
            repeat_reg <= '0; group_map_reg <= '0;
            rep_delay_reg <= 16'd100; rep_interval_reg <= 16'd20; long_ticks_reg <= 16'd200;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ON_PRESS:     on_press_reg <= cfg_wdata[7:0];
                CFG_ON_RELEASE:   on_release_reg <= cfg_wdata[7:0];
                CFG_LONG_PRESS:   long_press_reg <= cfg_wdata[7:0];
                CFG_REPEAT:       repeat_reg <= cfg_wdata[7:0];
                CFG_GROUP_MAP:    group_map_reg <= cfg_wdata;
                CFG_REP_DELAY:    rep_delay_reg <= cfg_wdata[15:0];
                CFG_REP_INTERVAL: rep_interval_reg <= cfg_wdata[15:0];
                CFG_LONG_TICKS:   long_ticks_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    assign key8 = 8'(key_reg);
    assign cur = keys_reg[key_reg];
    always_comb begin
        if (key8 < 8'd8) begin
            pin_pr = !in_reg[key8[2:0]];
            grp = group_map_reg[key8[2:0]*3 +: 3];
            kcfg.on_press = on_press_reg[key8[2:0]];
            kcfg.on_release = on_release_reg[key8[2:0]];
            kcfg.long_press = long_press_reg[key8[2:0]];
            kcfg.repeat_en = repeat_reg[key8[2:0]];
        end else begin
            pin_pr = 1'b0;
            grp = 3'd0;
            kcfg.on_press = 1'b0;
            kcfg.on_release = 1'b0;
            kcfg.long_press = 1'b0;
            kcfg.repeat_en = 1'b0;
        end
        kcfg.group = grp;
        kcfg.rep_delay = rep_delay_reg;
        kcfg.rep_interval = rep_interval_reg;
        kcfg.long_ticks = long_ticks_reg;
        lock_in = lock_reg[grp];
    end

    kde_key_unit #(.DEBOUNCE_TICKS(DEBOUNCE_TICKS)) u_unit (
        .st_in(cur), .cfg(kcfg), .pin_pressed(pin_pr), .lock_in(lock_in),
        .st_out(upd), .lock_out(lock_out)
    );

    // the output register can take a new word once the waiting one leaves
    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            SEQ_IDLE: if (s_axis_tvalid && s_axis_tready) state_next = SEQ_ACK;
            SEQ_ACK:  state_next = SEQ_KEY;
            SEQ_KEY:  if (key_reg == LastKey) state_next = SEQ_OUT;
            SEQ_OUT:  if (out_free) state_next = SEQ_IDLE;
            default:  state_next = SEQ_IDLE;
        endcase
    end

    assign s_axis_tready = (state_reg == SEQ_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SEQ_IDLE;
            key_reg <= '0;
            lock_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_KEYS; i++) keys_reg[i] <= '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                SEQ_IDLE: begin
                    key_reg <= '0;
                    if (s_axis_tvalid && s_axis_tready) in_reg <= s_axis_tdata;
                end
                SEQ_ACK: begin
                    // clear ready flags named by the ack mask
                    for (int i = 0; i < NUM_KEYS && i < 8; i++)
                        if (in_reg[8+i]) keys_reg[i].ready <= 1'b0;
                end
                SEQ_KEY: begin
                    keys_reg[key_reg] <= upd;
                    if (grp != 3'd0) lock_reg[grp] <= lock_out;
                    if (key_reg != LastKey) key_reg <= key_reg + 1'b1;
                end
                default: ;
            endcase
            if (state_reg == SEQ_OUT && out_free) out_valid_reg <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == SEQ_OUT && out_free) begin
            logic anyp, anyq;
            logic [39:0] word;
            anyp = 1'b0;
            anyq = 1'b0;
            word = '0;
            for (int i = 0; i < NUM_KEYS; i++) begin
                anyp = anyp | keys_reg[i].pressed;
                anyq = anyq | keys_reg[i].proc;
                if (i < 8) begin
                    word[i] = keys_reg[i].ready;
                    word[8+i] = keys_reg[i].pressed;
                    word[16+i] = keys_reg[i].proc;
                    word[24+i] = keys_reg[i].after;
                end
            end
            word[32] = !anyp;
            word[33] = !anyq;
            out_reg <= word;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_reg;

    `KDE_ASSERT_IMP(a_no_accept_busy, aclk, aresetn, state_reg != SEQ_IDLE, !s_axis_tready)
    `KDE_ASSERT_NXT(a_out_after_seq, aclk, aresetn, state_reg == SEQ_OUT, m_axis_tvalid)
    `KDE_ASSERT_IMP(a_unused_bits, aclk, aresetn, m_axis_tvalid, m_axis_tdata[39:34] == 6'd0)
endmodule
